// File: rtl/egs_pkg.sv
// Shared types and constants for the elliptical Gaussian spot model.
`timescale 1ns / 1ps
`default_nettype none

package egs_pkg;

    // Register map, one 32-bit word per register
    typedef enum logic [2:0] {
        REG_AMPLITUDE     = 3'd0,
        REG_CENTER_X      = 3'd1,
        REG_CENTER_Y      = 3'd2,
        REG_INV_TWO_VAR_X = 3'd3,
        REG_INV_TWO_VAR_Y = 3'd4,
        REG_OFFSET        = 3'd5,
        REG_SLOPE_X       = 3'd6,
        REG_SLOPE_Y       = 3'd7
    } reg_idx_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [31:0] amplitude;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic        [31:0] inv_two_var_x;
        logic        [31:0] inv_two_var_y;
        logic signed [31:0] offset;
        logic signed [31:0] slope_x;
        logic signed [31:0] slope_y;
    } cfg_t;

    // Reset values
    localparam logic signed [31:0] AMPLITUDE_RST = 32'sd65536;
    localparam logic        [31:0] INV_VAR_RST   = 32'h8000_0000;

    // round(2^20 / ln 2) and the exponent bias, both Q.20
    localparam logic [20:0] EXP_A_Q = 21'd1512775;
    localparam logic [37:0] EXP_C   = 38'd60801;

    // Right shift of 20 + s reaches 64 (term vanishes) once s hits this
    localparam logic [17:0] SHIFT_LIMIT = 18'd44;

    // Widths along the path
    localparam int unsigned BG_W  = 50;   // background, Q.16
    localparam int unsigned G_W   = 33;   // gaussian term, Q.16
    localparam int unsigned OUT_W = 48;

endpackage

`default_nettype wire

// File: rtl/egs_cfg.sv
// APB register file holding the spot parameters.
`timescale 1ns / 1ps
`default_nettype none

module egs_cfg
    import egs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_AMPLITUDE:     cfg_next.amplitude     = pwdata;
                REG_CENTER_X:      cfg_next.center_x      = pwdata[23:0];
                REG_CENTER_Y:      cfg_next.center_y      = pwdata[23:0];
                REG_INV_TWO_VAR_X: cfg_next.inv_two_var_x = pwdata;
                REG_INV_TWO_VAR_Y: cfg_next.inv_two_var_y = pwdata;
                REG_OFFSET:        cfg_next.offset        = pwdata;
                REG_SLOPE_X:       cfg_next.slope_x       = pwdata;
                REG_SLOPE_Y:       cfg_next.slope_y       = pwdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude     <= AMPLITUDE_RST;
            cfg_reg.center_x      <= '0;
            cfg_reg.center_y      <= '0;
            cfg_reg.inv_two_var_x <= INV_VAR_RST;
            cfg_reg.inv_two_var_y <= INV_VAR_RST;
            cfg_reg.offset        <= '0;
            cfg_reg.slope_x       <= '0;
            cfg_reg.slope_y       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux, narrow fields zero-extended
    always_comb
    begin
        unique case (idx)
            REG_AMPLITUDE:     prdata = cfg_reg.amplitude;
            REG_CENTER_X:      prdata = {8'd0, cfg_reg.center_x};
            REG_CENTER_Y:      prdata = {8'd0, cfg_reg.center_y};
            REG_INV_TWO_VAR_X: prdata = cfg_reg.inv_two_var_x;
            REG_INV_TWO_VAR_Y: prdata = cfg_reg.inv_two_var_y;
            REG_OFFSET:        prdata = cfg_reg.offset;
            REG_SLOPE_X:       prdata = cfg_reg.slope_x;
            REG_SLOPE_Y:       prdata = cfg_reg.slope_y;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/egs_dist.sv
// Four-stage front end: scaled squared distance u and plane background.
`timescale 1ns / 1ps
`default_nettype none

module egs_dist
    import egs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [23:0]     x,
    input  wire logic signed [23:0]     y,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic             [31:0]     u,
    output logic signed [BG_W-1:0]      bg
);

    localparam int unsigned NST = 4;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    // Stage 1: differences and slope products
    logic signed [24:0] dx_next, dy_next;
    logic        [24:0] adx_reg, ady_reg;
    logic signed [55:0] px_reg, py_reg;

    // Stage 2: squares and background
    logic        [49:0] sqx_full, sqy_full;
    logic        [48:0] sqx_reg, sqy_reg;
    logic signed [56:0] bgsum;
    logic signed [BG_W-1:0] bg2_next, bg2_reg, bg3_reg, bg4_reg;

    // Stage 3: partial products against the reciprocals
    logic [48:0] phx_reg, phy_reg;
    logic [63:0] plx_full, ply_full;
    logic [31:0] plx_reg, ply_reg;

    // Stage 4: sum and clamp
    logic [50:0] u_sum;
    logic [31:0] u_next, u_reg;

    // Elastic flow: a stage loads when empty or when its successor moves
    always_comb
    begin
        rdy[NST] = !out_stall;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1
    assign dx_next = 25'(x) - 25'(cfg.center_x);
    assign dy_next = 25'(y) - 25'(cfg.center_y);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            adx_reg <= dx_next[24] ? 25'(-dx_next) : 25'(dx_next);
            ady_reg <= dy_next[24] ? 25'(-dy_next) : 25'(dy_next);
            px_reg  <= cfg.slope_x * x;
            py_reg  <= cfg.slope_y * y;
        end
    end

    // Stage 2
    assign sqx_full = 50'(adx_reg) * 50'(adx_reg);
    assign sqy_full = 50'(ady_reg) * 50'(ady_reg);
    assign bgsum    = 57'(px_reg) + 57'(py_reg);
    // floor division by 256, then add the constant level
    assign bg2_next = BG_W'(bgsum >>> 8) + BG_W'(cfg.offset);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            sqx_reg <= sqx_full[48:0];
            sqy_reg <= sqy_full[48:0];
            bg2_reg <= bg2_next;
        end
    end

    // Stage 3: floor(sq * k / 2^32) split at bit 32 of sq
    assign plx_full = 64'(sqx_reg[31:0]) * 64'(cfg.inv_two_var_x);
    assign ply_full = 64'(sqy_reg[31:0]) * 64'(cfg.inv_two_var_y);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            phx_reg <= 49'(sqx_reg[48:32]) * 49'(cfg.inv_two_var_x);
            phy_reg <= 49'(sqy_reg[48:32]) * 49'(cfg.inv_two_var_y);
            plx_reg <= plx_full[63:32];
            ply_reg <= ply_full[63:32];
            bg3_reg <= bg2_reg;
        end
    end

    // Stage 4: anything past 32 bits already drives the exponential to zero
    assign u_sum  = 51'(phx_reg) + 51'(phy_reg) + 51'(plx_reg) + 51'(ply_reg);
    assign u_next = (u_sum[50:32] != '0) ? 32'hFFFF_FFFF : u_sum[31:0];

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            u_reg   <= u_next;
            bg4_reg <= bg3_reg;
        end
    end

    assign u  = u_reg;
    assign bg = bg4_reg;

endmodule

`default_nettype wire

// File: rtl/egs_exp.sv
// Four-stage exponential (linear mantissa and power-of-two shift) scaled by the amplitude.
`timescale 1ns / 1ps
`default_nettype none

module egs_exp
    import egs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic        [31:0]     u,
    input  wire logic signed [BG_W-1:0] bg_in,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [G_W-1:0]       gauss,
    output logic signed [BG_W-1:0]      bg_out
);

    localparam int unsigned NST = 4;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    // Stage 5: u * log2(e) in Q.36
    logic [52:0] prod_reg;
    logic signed [BG_W-1:0] bg5_reg, bg6_reg, bg7_reg, bg8_reg;

    // Stage 6: exponent split into shift and mantissa
    logic [53:0] prod_rnd;
    logic [37:0] ne;
    logic [17:0] s_full;
    logic [20:0] m_next, m_reg;
    logic        ok_reg;
    logic [5:0]  s_reg;

    // Stage 7: amplitude times mantissa
    logic [31:0] abs_amp;
    logic [52:0] mag_reg;
    logic        ok7_reg, neg7_reg;
    logic [5:0]  s7_reg;

    // Stage 8: shift and sign
    logic [5:0]  sh;
    logic [52:0] shifted;
    logic [G_W-1:0] mag32;
    logic signed [G_W-1:0] g_next, g_reg;

    always_comb
    begin
        rdy[NST] = !out_stall;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 5
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            prod_reg <= 53'(u) * 53'(EXP_A_Q);
            bg5_reg  <= bg_in;
        end
    end

    // Stage 6: ne = ceil(prod / 2^16) + C, s = ceil(ne / 2^20)
    assign prod_rnd = 54'(prod_reg) + 54'(16'hFFFF);
    assign ne       = 38'(prod_rnd[53:16]) + EXP_C;
    assign s_full   = ne[37:20] + 18'(ne[19:0] != '0);
    // m = 2^20 + s*2^20 - ne lies in [2^20, 2^21)
    assign m_next   = (ne[19:0] == '0) ? 21'h10_0000
                                       : 21'(22'h20_0000 - 22'(ne[19:0]));

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            m_reg   <= m_next;
            ok_reg  <= (s_full < SHIFT_LIMIT);
            s_reg   <= s_full[5:0];
            bg6_reg <= bg5_reg;
        end
    end

    // Stage 7
    assign abs_amp = cfg.amplitude[31] ? 32'(-cfg.amplitude) : 32'(cfg.amplitude);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            mag_reg  <= 53'(abs_amp) * 53'(m_reg);
            ok7_reg  <= ok_reg;
            neg7_reg <= cfg.amplitude[31];
            s7_reg   <= s_reg;
            bg7_reg  <= bg6_reg;
        end
    end

    // Stage 8: truncate toward zero, then restore the sign
    assign sh      = 6'd20 + s7_reg;
    assign shifted = mag_reg >> sh;
    assign mag32   = G_W'(shifted[31:0]);

    always_comb
    begin
        if (!ok7_reg)
        begin
            g_next = '0;
        end
        else if (neg7_reg)
        begin
            g_next = -$signed(mag32);
        end
        else
        begin
            g_next = $signed(mag32);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            g_reg   <= g_next;
            bg8_reg <= bg7_reg;
        end
    end

    assign gauss  = g_reg;
    assign bg_out = bg8_reg;

endmodule

`default_nettype wire

// File: rtl/elliptical_gaussian_spot_model.sv
// Top level: elliptical Gaussian spot plus tilted plane, one sample per unstalled clock.
//
// Samples (x, y) arrive on the sample channel (sample_valid / sample_stall),
// results leave on the result channel (result_valid / result_stall / value).
// A transaction happens at a rising edge with valid high and stall low.
// The datapath is a 9-stage elastic pipeline, and one sample per cycle is
// sustained as long as the receiver does not stall the result channel.
// The depth is set by the multiplier chain (squares, reciprocal products,
// log2(e) scaling, amplitude product) with a register after each.
// When the receiver stalls, results collect in the empty stages; the sample
// channel stalls only once every stage holds a transaction. Nothing is lost
// or repeated across a stall. Parameters are written over the APB port
// (byte addresses 0x00..0x1C); the user must write them only while no
// transaction is in flight, and the block itself does not enforce this.
// Reset empties the pipeline and loads amplitude 1.0, zero center, zero
// background and reciprocals 0.5.
`timescale 1ns / 1ps
`default_nettype none

module elliptical_gaussian_spot_model
    import egs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic signed [23:0] x,
    input  wire logic signed [23:0] y,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [OUT_W-1:0] value
);

    cfg_t cfg;

    logic                   d_valid, d_stall;
    logic [31:0]            d_u;
    logic signed [BG_W-1:0] d_bg;

    logic                   e_valid, e_stall;
    logic signed [G_W-1:0]  e_gauss;
    logic signed [BG_W-1:0] e_bg;

    logic                   out_rdy;
    logic                   out_valid_reg;
    logic signed [50:0]     total;
    logic signed [OUT_W-1:0] value_next, value_reg;

    egs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    egs_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (sample_valid),
        .in_stall  (sample_stall),
        .x         (x),
        .y         (y),
        .out_valid (d_valid),
        .out_stall (d_stall),
        .u         (d_u),
        .bg        (d_bg)
    );

    egs_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (d_valid),
        .in_stall  (d_stall),
        .u         (d_u),
        .bg_in     (d_bg),
        .out_valid (e_valid),
        .out_stall (e_stall),
        .gauss     (e_gauss),
        .bg_out    (e_bg)
    );

    // Output stage: add and saturate to 48 bits
    assign out_rdy = !out_valid_reg || !result_stall;
    assign e_stall = !out_rdy;

    assign total = 51'(e_gauss) + 51'(e_bg);

    always_comb
    begin
        if (total[50:47] == 4'b0000 || total[50:47] == 4'b1111)
        begin
            value_next = total[OUT_W-1:0];
        end
        else if (total[50])
        begin
            value_next = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            value_next = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_valid_reg <= e_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            value_reg <= value_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = value_reg;

endmodule

`default_nettype wire

// File: tb/sv/elliptical_gaussian_spot_model_tb.sv
// Self-checking testbench for the elliptical Gaussian spot model with plane background.
`timescale 1ns / 1ps

module elliptical_gaussian_spot_model_tb
    import egs_pkg::*;
();

    // Fixed-point constants of the exp approximation, Q.20
    localparam logic [63:0] LOG2E_Q20      = 64'd1512775;
    localparam logic [63:0] EXP_OFFSET_Q20 = 64'd60801;
    // Saturation bounds of the 48-bit result
    localparam longint VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
    } coord_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [4:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    sample_valid = 1'b0;
    logic                    sample_stall;
    logic signed [23:0]      x = '0;
    logic signed [23:0]      y = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic signed [OUT_W-1:0] value;

    // Shadow of the parameter registers, updated on every APB write
    cfg_t                    model_cfg;
    coord_t                  pending_coords[$];
    logic signed [47:0]      expected_values[$];
    coord_t                  next_coord;
    logic signed [47:0]      want_value;
    bit                      idle_on = 1'b0;
    int                      send_left = 0;
    int                      stall_left = 0;
    int                      mismatch_count = 0;
    int                      samples_taken = 0;
    int                      results_seen = 0;
    int                      settings_loaded = 0;

    elliptical_gaussian_spot_model dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .x            (x),
        .y            (y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Expected model value at one sample under the current register shadow
    function automatic logic signed [47:0] spot_value(input logic signed [23:0] px,
                                                      input logic signed [23:0] py);
        longint      dx, dy, amp, prod, gauss, bg, total;
        logic [79:0] sqx, sqy, usum;
        logic [63:0] u, biased, s, mant, mag, amp_mag;
        dx = longint'(px) - longint'(model_cfg.center_x);
        dy = longint'(py) - longint'(model_cfg.center_y);
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dy < 0)
        begin
            dy = -dy;
        end
        // Squares in Q.16 times the reciprocals, scaled down by 2^32
        sqx = dx * dx;
        sqy = dy * dy;
        sqx = (sqx * 80'(model_cfg.inv_two_var_x)) >> 32;
        sqy = (sqy * 80'(model_cfg.inv_two_var_y)) >> 32;
        usum = sqx + sqy;
        u = (usum > 80'hFFFF_FFFF) ? 64'hFFFF_FFFF : usum[63:0];
        // Negated exponent in Q.20, then shift count and mantissa
        biased = ((u * LOG2E_Q20 + 64'hFFFF) >> 16) + EXP_OFFSET_Q20;
        s = (biased + 64'hF_FFFF) >> 20;
        mant = (64'd1 << 20) + (s << 20) - biased;
        gauss = 0;
        if (s < 64'd44)
        begin
            amp = longint'(model_cfg.amplitude);
            amp_mag = (amp < 0) ? -amp : amp;
            mag = (amp_mag * mant) >> (20 + s);
            // truncation toward zero for a negative peak
            gauss = (amp < 0) ? -longint'(mag) : longint'(mag);
        end
        // Plane background, floor division by 256
        prod = longint'(model_cfg.slope_x) * longint'(px)
             + longint'(model_cfg.slope_y) * longint'(py);
        bg = (prod >>> 8) + longint'(model_cfg.offset);
        total = gauss + bg;
        if (total > VALUE_MAX)
        begin
            total = VALUE_MAX;
        end
        else if (total < VALUE_MIN)
        begin
            total = VALUE_MIN;
        end
        return total[47:0];
    endfunction

    // Idle length: mostly none or short, sometimes long
    function automatic int idle_len();
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // Signed word with a random magnitude scale, extremes now and then
    function automatic logic [31:0] spread_word();
        logic [31:0] w;
        case ($urandom_range(0, 19))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            default:
            begin
                w = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                begin
                    w = -w;
                end
            end
        endcase
        return w;
    endfunction

    // Reciprocal with a log-spread magnitude, zero and full scale included
    function automatic logic [31:0] recip_word();
        case ($urandom_range(0, 19))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.amplitude     = spread_word();
        c.center_x      = 24'($urandom);
        c.center_y      = 24'($urandom);
        c.inv_two_var_x = recip_word();
        c.inv_two_var_y = recip_word();
        c.offset        = spread_word();
        c.slope_x       = ($urandom_range(0, 2) == 0) ? 32'h0 : spread_word();
        c.slope_y       = ($urandom_range(0, 2) == 0) ? 32'h0 : spread_word();
        return c;
    endfunction

    function automatic logic signed [23:0] rim_coord();
        case ($urandom_range(0, 4))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'sh000000;
            3: return 24'sh000001;
            default: return -24'sd1;
        endcase
    endfunction

    // Mostly samples inside a random window around the spot, some anywhere
    function automatic coord_t pick_coord();
        coord_t c;
        int     r;
        int     span;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            span = 1 << $urandom_range(0, 14);
            c.x = model_cfg.center_x + 24'($urandom_range(0, 2 * span) - span);
            c.y = model_cfg.center_y + 24'($urandom_range(0, 2 * span) - span);
        end
        else if (r < 85)
        begin
            c.x = 24'($urandom);
            c.y = 24'($urandom);
        end
        else
        begin
            c.x = rim_coord();
            c.y = rim_coord();
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic add_point(input logic signed [23:0] px, input logic signed [23:0] py);
        coord_t c;
        c.x = px;
        c.y = py;
        pending_coords.push_back(c);
    endtask

    // One APB transfer: setup, then access until pready
    task automatic apb_cycle(input reg_idx_t idx, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(negedge clk);
        end
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write one register, update the shadow, read it back
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        logic [31:0] rd;
        logic [31:0] mask;
        apb_cycle(idx, 1'b1, data, rd);
        mask = 32'hFFFF_FFFF;
        case (idx)
            REG_AMPLITUDE:     model_cfg.amplitude = data;
            REG_CENTER_X:
            begin
                model_cfg.center_x = data[23:0];
                mask = 32'h00FF_FFFF;
            end
            REG_CENTER_Y:
            begin
                model_cfg.center_y = data[23:0];
                mask = 32'h00FF_FFFF;
            end
            REG_INV_TWO_VAR_X: model_cfg.inv_two_var_x = data;
            REG_INV_TWO_VAR_Y: model_cfg.inv_two_var_y = data;
            REG_OFFSET:        model_cfg.offset = data;
            REG_SLOPE_X:       model_cfg.slope_x = data;
            REG_SLOPE_Y:       model_cfg.slope_y = data;
            default: ;
        endcase
        apb_cycle(idx, 1'b0, 32'h0, rd);
        if (((rd ^ data) & mask) != 32'h0)
        begin
            report_mismatch($sformatf("register %s readback: expected %h, got %h",
                                      idx.name(), data & mask, rd & mask));
        end
    endtask

    task automatic write_setting(input cfg_t c);
        write_reg(REG_AMPLITUDE, c.amplitude);
        write_reg(REG_CENTER_X, 32'(c.center_x));
        write_reg(REG_CENTER_Y, 32'(c.center_y));
        write_reg(REG_INV_TWO_VAR_X, c.inv_two_var_x);
        write_reg(REG_INV_TWO_VAR_Y, c.inv_two_var_y);
        write_reg(REG_OFFSET, c.offset);
        write_reg(REG_SLOPE_X, c.slope_x);
        write_reg(REG_SLOPE_Y, c.slope_y);
        settings_loaded++;
    endtask

    // Hold off until every queued sample went in and every result came back;
    // checked between edges so the driver and monitor updates have settled
    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_coords.size() != 0 || sample_valid || expected_values.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sample driver: predicts on each accepted transaction, then loads the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            x            <= '0;
            y            <= '0;
            send_left    <= 0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (sample_valid)
            begin
                expected_values.push_back(spot_value(x, y));
                samples_taken++;
            end
            if (send_left > 0)
            begin
                send_left    <= send_left - 1;
                sample_valid <= 1'b0;
            end
            else if (pending_coords.size() != 0)
            begin
                next_coord   = pending_coords.pop_front();
                x            <= next_coord.x;
                y            <= next_coord.y;
                sample_valid <= 1'b1;
                send_left    <= idle_len();
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks against the oldest prediction, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_values.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with nothing pending: value %0d",
                                              results_seen, value));
                end
                else
                begin
                    want_value = expected_values.pop_front();
                    if (value !== want_value)
                    begin
                        report_mismatch($sformatf("result %0d value: expected %0d, got %0d",
                                                  results_seen, want_value, value));
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left   <= idle_len();
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        cfg_t setting;
        // Register values after reset
        model_cfg = {32'h0001_0000, 24'h0, 24'h0, 32'h8000_0000, 32'h8000_0000,
                     32'h0, 32'h0, 32'h0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset parameters: peak, unit steps and the corners
        add_point(24'sh000000, 24'sh000000);
        add_point(24'sh000100, 24'sh000100);
        add_point(-24'sd256, 24'sh000000);
        add_point(24'sh7FFFFF, 24'sh7FFFFF);
        add_point(24'sh800000, 24'sh800000);
        add_point(24'sh7FFFFF, 24'sh800000);
        wait_until_drained();

        // Negative peak off center: tail truncates toward zero, far points give no term
        // order: amplitude, center x/y, kx, ky, offset, slope x/y
        setting = {32'hFFFE_DCBB, 24'h001000, 24'hFFF800, 32'h8000_0000, 32'h8000_0000,
                   32'h0, 32'h0, 32'h0};
        write_setting(setting);
        add_point(model_cfg.center_x, model_cfg.center_y);
        add_point(model_cfg.center_x + 24'sd64, model_cfg.center_y);
        add_point(model_cfg.center_x + 24'sd600, model_cfg.center_y);
        add_point(model_cfg.center_x + 24'sd1000, model_cfg.center_y);
        add_point(model_cfg.center_x + 24'sd1400, model_cfg.center_y);
        add_point(model_cfg.center_x + 24'sd3000, model_cfg.center_y - 24'sd1500);
        wait_until_drained();

        idle_on = 1'b1;
        // Largest positive parameters, flat along x: saturates high at the corner
        setting = {32'h7FFF_FFFF, 24'h7FFFFF, 24'h800000, 32'h0, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        write_setting(setting);
        add_point(24'sh7FFFFF, 24'sh7FFFFF);
        add_point(24'sh7FFFFF, 24'sh800000);
        add_point(24'sh800000, 24'sh800000);
        add_point(24'sh000000, 24'sh000000);
        add_point(24'sh000000, 24'sh800010);
        wait_until_drained();

        // Most negative parameters, flat along y: saturates low, clamped exponent
        setting = {32'h8000_0000, 24'h800000, 24'h7FFFFF, 32'hFFFF_FFFF, 32'h0,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        write_setting(setting);
        add_point(24'sh7FFFFF, 24'sh7FFFFF);
        add_point(24'sh800000, 24'sh7FFFFF);
        add_point(24'sh800000, 24'sh800000);
        add_point(24'sh7FFFFF, 24'sh800000);
        add_point(24'sh800100, 24'sh000000);
        wait_until_drained();

        // Random parameter sets, each followed by a full drain
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            idle_on = (chunk != 2);
            write_setting(random_setting());
            repeat (110) pending_coords.push_back(pick_coord());
            wait_until_drained();
        end

        repeat (30) @(posedge clk);
        if (expected_values.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
        end
        $display("Checked %0d results from %0d samples under %0d parameter sets,",
                 results_seen, samples_taken, settings_loaded);
        $display("covering peak, tails, far field, flat axes and both saturation limits");
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/egs_pkg.sv
rtl/egs_cfg.sv
rtl/egs_dist.sv
rtl/egs_exp.sv
rtl/elliptical_gaussian_spot_model.sv
tb/sv/elliptical_gaussian_spot_model_tb.sv
